// ===== rtl/rbi_pkg.sv =====
// shared constants and helpers for the ray box intersection block
`timescale 1ns / 1ps
package rbi_pkg;

	// number of spatial axes
	localparam int NAXIS = 3;

	// fraction bits of an entry distance for a given coordinate width
	function automatic int t_frac_bits(input int cw);
		return 62 - cw;
	endfunction

endpackage

// ===== rtl/rbi_if.sv =====
// item channels and configuration channel of the ray box intersection block
`timescale 1ns / 1ps
interface rbi_in_if #(parameter int CW = 32);
	logic valid;
	logic ready;
	logic signed [CW-1:0] box_min_x;
	logic signed [CW-1:0] box_min_y;
	logic signed [CW-1:0] box_min_z;
	logic signed [CW-1:0] box_max_x;
	logic signed [CW-1:0] box_max_y;
	logic signed [CW-1:0] box_max_z;
	logic signed [CW-1:0] seg_start_x;
	logic signed [CW-1:0] seg_start_y;
	logic signed [CW-1:0] seg_start_z;
	logic signed [CW-1:0] seg_end_x;
	logic signed [CW-1:0] seg_end_y;
	logic signed [CW-1:0] seg_end_z;

	modport source (output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
		box_max_z, seg_start_x, seg_start_y, seg_start_z, seg_end_x, seg_end_y, seg_end_z,
		input ready);
	modport sink (input valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
		box_max_z, seg_start_x, seg_start_y, seg_start_z, seg_end_x, seg_end_y, seg_end_z,
		output ready);
endinterface

interface rbi_out_if #(parameter int CW = 32);
	logic valid;
	logic ready;
	logic hit;
	logic starts_inside;
	logic signed [CW-1:0] hit_x;
	logic signed [CW-1:0] hit_y;
	logic signed [CW-1:0] hit_z;

	modport source (output valid, hit, starts_inside, hit_x, hit_y, hit_z, input ready);
	modport sink (input valid, hit, starts_inside, hit_x, hit_y, hit_z, output ready);
endinterface

interface rbi_cfg_if;
	logic valid;
	logic ready;
	logic [15:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ===== rtl/ray_box_intersect_top.sv =====
// Segment versus axis-aligned box test, fully pipelined: one item per cycle while the result side
// is ready. The restoring divider forms one quotient bit of the per-axis entry distance in each
// of its 63 - COORD_WIDTH stages.
// A start inside the box is a hit at the start point; otherwise the largest entry distance
// picks the plane and the other two coordinates must lie within the box widened by
// the configured tolerance. Stalls at the result side back up stage by stage; empty stages fill.
`timescale 1ns / 1ps
module ray_box_intersect_top #(
	parameter int COORD_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	rbi_in_if.sink seg_in,
	rbi_out_if.source res_out,
	rbi_cfg_if.sink cfg
);
	import rbi_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int TF = t_frac_bits(CW);
	localparam int TW = TF + 1;
	localparam int AW = 5 * CW + 3;
	localparam int SW = NAXIS * AW + 1;
	localparam int PW = TW + CW + 1;
	localparam int FW = CW + 4;
	localparam int EW = CW + 5;

	// tolerance register
	logic [15:0] tol_q;
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= 16'd1;
		end else if (cfg.valid) begin
			tol_q <= cfg.data;
		end
	end

	// per-axis views of the input item
	logic signed [CW-1:0] lo_in [NAXIS], hi_in [NAXIS], org_in [NAXIS], end_in [NAXIS];
	assign lo_in[0] = seg_in.box_min_x;
	assign lo_in[1] = seg_in.box_min_y;
	assign lo_in[2] = seg_in.box_min_z;
	assign hi_in[0] = seg_in.box_max_x;
	assign hi_in[1] = seg_in.box_max_y;
	assign hi_in[2] = seg_in.box_max_z;
	assign org_in[0] = seg_in.seg_start_x;
	assign org_in[1] = seg_in.seg_start_y;
	assign org_in[2] = seg_in.seg_start_z;
	assign end_in[0] = seg_in.seg_end_x;
	assign end_in[1] = seg_in.seg_end_y;
	assign end_in[2] = seg_in.seg_end_z;

	logic v1, v2, v3, v4, v5, v6, vd;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy_div;

	assign rdy6 = !v6 || res_out.ready;
	assign rdy5 = !v5 || rdy6;
	assign rdy4 = !v4 || rdy5;
	assign rdy3 = !v3 || rdy4;
	assign rdy2 = !v2 || rdy_div;
	assign rdy1 = !v1 || rdy2;
	assign seg_in.ready = rdy1;

	// valid bits of all top-level stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1 <= 1'b0;
			v2 <= 1'b0;
			v3 <= 1'b0;
			v4 <= 1'b0;
			v5 <= 1'b0;
			v6 <= 1'b0;
		end else begin
			if (rdy1) begin
				v1 <= seg_in.valid;
			end
			if (rdy2) begin
				v2 <= v1;
			end
			if (rdy3) begin
				v3 <= vd;
			end
			if (rdy4) begin
				v4 <= v3;
			end
			if (rdy5) begin
				v5 <= v4;
			end
			if (rdy6) begin
				v6 <= v5;
			end
		end
	end

	// stage 1: slab tests, face offsets and direction
	logic signed [CW-1:0] org_s1 [NAXIS], lo_s1 [NAXIS], hi_s1 [NAXIS];
	logic signed [CW:0] dir_s1 [NAXIS], dh_s1 [NAXIS], dl_s1 [NAXIS];
	logic gt_s1 [NAXIS], lt_s1 [NAXIS];
	always_ff @(posedge clk) begin
		if (seg_in.valid && rdy1) begin
			for (int i = 0; i < NAXIS; i++) begin
				org_s1[i] <= org_in[i];
				lo_s1[i] <= lo_in[i];
				hi_s1[i] <= hi_in[i];
				dir_s1[i] <= $signed({end_in[i][CW-1], end_in[i]})
					- $signed({org_in[i][CW-1], org_in[i]});
				dh_s1[i] <= $signed({hi_in[i][CW-1], hi_in[i]})
					- $signed({org_in[i][CW-1], org_in[i]});
				dl_s1[i] <= $signed({lo_in[i][CW-1], lo_in[i]})
					- $signed({org_in[i][CW-1], org_in[i]});
				gt_s1[i] <= org_in[i] > hi_in[i];
				lt_s1[i] <= org_in[i] < lo_in[i];
			end
		end
	end

	// stage 2: crossed face, magnitudes, sign of the distance
	logic signed [CW:0] num_c [NAXIS], nabs_c [NAXIS], dabs_c [NAXIS];
	logic signed [CW-1:0] face_c [NAXIS];
	always_comb begin
		for (int i = 0; i < NAXIS; i++) begin
			num_c[i] = gt_s1[i] ? dh_s1[i] : (lt_s1[i] ? dl_s1[i] : '0);
			face_c[i] = gt_s1[i] ? hi_s1[i] : (lt_s1[i] ? lo_s1[i] : '0);
			nabs_c[i] = num_c[i][CW] ? -num_c[i] : num_c[i];
			dabs_c[i] = dir_s1[i][CW] ? -dir_s1[i] : dir_s1[i];
		end
	end

	logic signed [CW-1:0] org_s2 [NAXIS], lo_s2 [NAXIS], hi_s2 [NAXIS], face_s2 [NAXIS];
	logic [CW-1:0] nmag_s2 [NAXIS];
	logic [CW:0] dmag_s2 [NAXIS];
	logic dneg_s2 [NAXIS], tv_s2 [NAXIS];
	logic outside_s2;
	always_ff @(posedge clk) begin
		if (v1 && rdy2) begin
			for (int i = 0; i < NAXIS; i++) begin
				org_s2[i] <= org_s1[i];
				lo_s2[i] <= lo_s1[i];
				hi_s2[i] <= hi_s1[i];
				face_s2[i] <= face_c[i];
				nmag_s2[i] <= nabs_c[i][CW-1:0];
				dmag_s2[i] <= dabs_c[i];
				dneg_s2[i] <= dir_s1[i][CW];
				tv_s2[i] <= (num_c[i] != '0) && (dir_s1[i] != '0)
					&& (num_c[i][CW] == dir_s1[i][CW]);
			end
			outside_s2 <= gt_s1[0] || lt_s1[0] || gt_s1[1] || lt_s1[1]
				|| gt_s1[2] || lt_s1[2];
		end
	end

	// divider, carrying the rest of the item alongside
	logic [SW-1:0] side_in, side_o;
	logic [TF:0] tq [NAXIS];
	logic ov1 [NAXIS];
	logic signed [CW-1:0] org_d [NAXIS], lo_d [NAXIS], hi_d [NAXIS], face_d [NAXIS];
	logic [CW:0] dmag_d [NAXIS];
	logic dneg_d [NAXIS], tv_d [NAXIS];
	logic outside_d;

	genvar g;
	generate
		for (g = 0; g < NAXIS; g++) begin : g_side
			assign side_in[g*AW +: AW] = {tv_s2[g], dneg_s2[g], dmag_s2[g], face_s2[g],
				hi_s2[g], lo_s2[g], org_s2[g]};
			assign org_d[g] = side_o[g*AW +: CW];
			assign lo_d[g] = side_o[g*AW + CW +: CW];
			assign hi_d[g] = side_o[g*AW + 2*CW +: CW];
			assign face_d[g] = side_o[g*AW + 3*CW +: CW];
			assign dmag_d[g] = side_o[g*AW + 4*CW +: CW+1];
			assign dneg_d[g] = side_o[g*AW + 5*CW + 1];
			assign tv_d[g] = side_o[g*AW + 5*CW + 2];
		end
	endgenerate
	assign side_in[SW-1] = outside_s2;
	assign outside_d = side_o[SW-1];

	rbi_div #(
		.CW(CW),
		.SW(SW)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.i_valid(v2),
		.i_ready(rdy_div),
		.n(nmag_s2),
		.d(dmag_s2),
		.side(side_in),
		.o_valid(vd),
		.o_ready(rdy3),
		.q(tq),
		.over1(ov1),
		.side_o(side_o)
	);

	// stage 3: pick the entry plane, lower axis wins ties
	logic [1:0] p_c;
	logic [TW-1:0] bt_c;
	logic bv_c;
	always_comb begin
		p_c = 2'd0;
		bt_c = tq[0];
		bv_c = tv_d[0];
		for (int i = 1; i < NAXIS; i++) begin
			if (tv_d[i] && (!bv_c || tq[i] > bt_c)) begin
				p_c = 2'(i);
				bt_c = tq[i];
				bv_c = 1'b1;
			end
		end
	end

	logic [1:0] p_s3;
	logic [TW-1:0] t_s3;
	logic ok_s3, outside_s3;
	logic signed [CW-1:0] org_s3 [NAXIS], lo_s3 [NAXIS], hi_s3 [NAXIS], face_s3 [NAXIS];
	logic [CW:0] dmag_s3 [NAXIS];
	logic dneg_s3 [NAXIS];
	always_ff @(posedge clk) begin
		if (vd && rdy3) begin
			p_s3 <= p_c;
			t_s3 <= bt_c;
			ok_s3 <= bv_c && !ov1[p_c];
			outside_s3 <= outside_d;
			for (int i = 0; i < NAXIS; i++) begin
				org_s3[i] <= org_d[i];
				lo_s3[i] <= lo_d[i];
				hi_s3[i] <= hi_d[i];
				face_s3[i] <= face_d[i];
				dmag_s3[i] <= dmag_d[i];
				dneg_s3[i] <= dneg_d[i];
			end
		end
	end

	// stage 4: distance times direction on each axis
	logic [1:0] p_s4;
	logic ok_s4, outside_s4;
	logic [PW-1:0] prod_s4 [NAXIS];
	logic signed [CW-1:0] org_s4 [NAXIS], lo_s4 [NAXIS], hi_s4 [NAXIS], face_s4 [NAXIS];
	logic dneg_s4 [NAXIS];
	always_ff @(posedge clk) begin
		if (v3 && rdy4) begin
			p_s4 <= p_s3;
			ok_s4 <= ok_s3;
			outside_s4 <= outside_s3;
			for (int i = 0; i < NAXIS; i++) begin
				prod_s4[i] <= PW'(t_s3) * PW'(dmag_s3[i]);
				org_s4[i] <= org_s3[i];
				lo_s4[i] <= lo_s3[i];
				hi_s4[i] <= hi_s3[i];
				face_s4[i] <= face_s3[i];
				dneg_s4[i] <= dneg_s3[i];
			end
		end
	end

	// stage 5: entry coordinate, floored toward minus infinity
	logic signed [FW-1:0] fc_c [NAXIS];
	always_comb begin
		for (int i = 0; i < NAXIS; i++) begin
			if (dneg_s4[i]) begin
				fc_c[i] = $signed({{4{org_s4[i][CW-1]}}, org_s4[i]})
					- $signed({2'b00, prod_s4[i][TF +: CW+2]})
					- $signed(FW'(|prod_s4[i][TF-1:0]));
			end else begin
				fc_c[i] = $signed({{4{org_s4[i][CW-1]}}, org_s4[i]})
					+ $signed({2'b00, prod_s4[i][TF +: CW+2]});
			end
		end
	end

	logic [1:0] p_s5;
	logic ok_s5, outside_s5;
	logic signed [FW-1:0] fc_s5 [NAXIS];
	logic signed [CW-1:0] org_s5 [NAXIS], lo_s5 [NAXIS], hi_s5 [NAXIS], face_s5 [NAXIS];
	always_ff @(posedge clk) begin
		if (v4 && rdy5) begin
			p_s5 <= p_s4;
			ok_s5 <= ok_s4;
			outside_s5 <= outside_s4;
			for (int i = 0; i < NAXIS; i++) begin
				fc_s5[i] <= fc_c[i];
				org_s5[i] <= org_s4[i];
				lo_s5[i] <= lo_s4[i];
				hi_s5[i] <= hi_s4[i];
				face_s5[i] <= face_s4[i];
			end
		end
	end

	// stage 6: tolerance check on the two other axes, result register
	logic bad_c;
	logic hit_c;
	logic signed [CW-1:0] coord_c [NAXIS];
	logic signed [EW-1:0] fcx, lox, hix, tolx;
	always_comb begin
		bad_c = 1'b0;
		fcx = '0;
		lox = '0;
		hix = '0;
		tolx = $signed({{(EW-16){1'b0}}, tol_q});
		for (int i = 0; i < NAXIS; i++) begin
			fcx = $signed({fc_s5[i][FW-1], fc_s5[i]});
			lox = $signed({{(EW-CW){lo_s5[i][CW-1]}}, lo_s5[i]});
			hix = $signed({{(EW-CW){hi_s5[i][CW-1]}}, hi_s5[i]});
			if (2'(i) != p_s5 && ((fcx + tolx < lox) || (fcx > hix + tolx))) begin
				bad_c = 1'b1;
			end
		end
		hit_c = !outside_s5 || (ok_s5 && !bad_c);
		for (int i = 0; i < NAXIS; i++) begin
			if (!outside_s5) begin
				coord_c[i] = org_s5[i];
			end else if (!hit_c) begin
				coord_c[i] = '0;
			end else if (2'(i) == p_s5) begin
				coord_c[i] = face_s5[i];
			end else begin
				coord_c[i] = fc_s5[i][CW-1:0];
			end
		end
	end

	logic hit_s6, inside_s6;
	logic signed [CW-1:0] coord_s6 [NAXIS];
	always_ff @(posedge clk) begin
		if (v5 && rdy6) begin
			hit_s6 <= hit_c;
			inside_s6 <= !outside_s5;
			for (int i = 0; i < NAXIS; i++) begin
				coord_s6[i] <= coord_c[i];
			end
		end
	end

	assign res_out.valid = v6;
	assign res_out.hit = hit_s6;
	assign res_out.starts_inside = inside_s6;
	assign res_out.hit_x = coord_s6[0];
	assign res_out.hit_y = coord_s6[1];
	assign res_out.hit_z = coord_s6[2];

	// a start inside the box is always reported as a hit
	a_inside_hit: assert property (@(posedge clk) disable iff (!arst_n)
		v6 |-> (!inside_s6 || hit_s6))
		else $error("start inside box without hit");

	// a miss carries a zero entry point
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v6 && !hit_s6) |-> (coord_s6[0] == '0 && coord_s6[1] == '0 && coord_s6[2] == '0))
		else $error("miss with nonzero entry point");

	// a tolerance write lands in the register
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg.valid && cfg.ready) |=> (tol_q == $past(cfg.data)))
		else $error("tolerance write lost");

	// a stalled result stage does not take a new item
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(v6 && !res_out.ready) |=> (v6 && hit_s6 == $past(hit_s6)))
		else $error("result overwritten while stalled");

endmodule

// ===== rtl/rbi_div.sv =====
// pipelined restoring divider for the three per-axis entry distances
`timescale 1ns / 1ps
module rbi_div #(
	parameter int CW = 32,
	parameter int SW = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic i_valid,
	output logic i_ready,
	input  logic [CW-1:0] n [rbi_pkg::NAXIS],
	input  logic [CW:0] d [rbi_pkg::NAXIS],
	input  logic [SW-1:0] side,
	output logic o_valid,
	input  logic o_ready,
	output logic [rbi_pkg::t_frac_bits(CW):0] q [rbi_pkg::NAXIS],
	output logic over1 [rbi_pkg::NAXIS],
	output logic [SW-1:0] side_o
);
	import rbi_pkg::*;

	localparam int TF = t_frac_bits(CW);
	localparam int STG = TF + 1;
	localparam int RW = CW + 2;

	logic [STG-1:0] v;
	logic [STG-1:0] rdy;
	logic [RW-1:0] rem_s [STG][NAXIS];
	logic [TF:0] q_s [STG][NAXIS];
	logic [CW:0] d_s [STG][NAXIS];
	logic g1_s [STG][NAXIS];
	logic ov_s [STG][NAXIS];
	logic [SW-1:0] side_s [STG];

	assign i_ready = rdy[0];
	assign o_valid = v[STG-1];
	assign side_o = side_s[STG-1];

	genvar k, a;
	generate
		for (k = 0; k < STG; k++) begin : g_stg
			logic pv;
			logic [RW-1:0] rem_c [NAXIS];
			logic [TF:0] q_c [NAXIS];
			logic g1_c [NAXIS];
			logic ov_c [NAXIS];

			// stall chain: a stage takes new data when empty or moving on
			if (k == STG - 1) begin : g_last
				assign rdy[k] = !v[k] || o_ready;
			end else begin : g_mid
				assign rdy[k] = !v[k] || rdy[k+1];
			end

			if (k == 0) begin : g_first
				assign pv = i_valid;
				// top quotient bit, also flags a distance above one
				for (a = 0; a < NAXIS; a++) begin : g_ax
					logic [RW-1:0] nx, dx;
					logic ge;
					assign nx = {2'b00, n[a]};
					assign dx = {1'b0, d[a]};
					assign ge = nx >= dx;
					assign rem_c[a] = ge ? nx - dx : nx;
					assign q_c[a] = (TF+1)'(ge);
					assign g1_c[a] = nx > dx;
					assign ov_c[a] = 1'b0;
				end
			end else begin : g_rest
				assign pv = v[k-1];
				// one quotient bit per stage
				for (a = 0; a < NAXIS; a++) begin : g_ax
					logic [RW-1:0] sh, dx;
					logic ge;
					assign sh = {rem_s[k-1][a][RW-2:0], 1'b0};
					assign dx = {1'b0, d_s[k-1][a]};
					assign ge = sh >= dx;
					assign rem_c[a] = ge ? sh - dx : sh;
					assign q_c[a] = {q_s[k-1][a][TF-1:0], ge};
					assign g1_c[a] = g1_s[k-1][a];
					if (k == 1) begin : g_ovf
						// remainder not below divisor: quotient is two or more
						assign ov_c[a] = rem_s[k-1][a] >= dx;
					end else begin : g_keep
						assign ov_c[a] = ov_s[k-1][a];
					end
				end
			end

			// stage valid
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v[k] <= 1'b0;
				end else if (rdy[k]) begin
					v[k] <= pv;
				end
			end

			// stage data
			always_ff @(posedge clk) begin
				if (pv && rdy[k]) begin
					for (int i = 0; i < NAXIS; i++) begin
						rem_s[k][i] <= rem_c[i];
						q_s[k][i] <= q_c[i];
						d_s[k][i] <= (k == 0) ? d[i] : d_s[(k == 0) ? 0 : k-1][i];
						g1_s[k][i] <= g1_c[i];
						ov_s[k][i] <= ov_c[i];
					end
					side_s[k] <= (k == 0) ? side : side_s[(k == 0) ? 0 : k-1];
				end
			end
		end

		// overflowed quotients only need to rank above one
		for (a = 0; a < NAXIS; a++) begin : g_out
			assign q[a] = ov_s[STG-1][a] ? '1 : q_s[STG-1][a];
			assign over1[a] = g1_s[STG-1][a];
		end
	endgenerate

endmodule

// ===== tb/tb_ray_box_intersect_top.sv =====
// self-checking testbench for the segment versus box intersection block
`timescale 1ns / 1ps
module tb_ray_box_intersect_top;
	import rbi_pkg::*;

	localparam int CW = 32;
	localparam int TFRAC = 30;
	localparam int LATENCY = 69 - CW;
	localparam int STALL_LIMIT = 5000;
	localparam int ITEMS_PER_PHASE = 290;
	localparam int LONG_HOLD = 400;

	typedef logic signed [CW-1:0] coord_t;

	typedef struct {
		coord_t bmin[NAXIS];
		coord_t bmax[NAXIS];
		coord_t p0[NAXIS];
		coord_t p1[NAXIS];
	} seg_t;

	typedef struct {
		bit hit;
		bit in_box;
		coord_t pt[NAXIS];
	} entry_t;

	typedef struct {
		seg_t s;
		bit typed;
		entry_t want;
	} row_t;

	logic clk;
	logic arst_n;
	logic [15:0] tol_shadow;
	entry_t entry_q[$];
	row_t dir_rows[$];
	int errors;
	int rx_count;
	int idle_cycles;

	rbi_in_if #(.CW(CW)) seg_if();
	rbi_out_if #(.CW(CW)) res_if();
	rbi_cfg_if cfg_if();

	ray_box_intersect_top #(.COORD_WIDTH(CW)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.seg_in(seg_if),
		.res_out(res_if),
		.cfg(cfg_if)
	);

	// clock, 12 ns period
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic longint unsigned absval(input longint v);
		return (v < 0) ? longint'(-v) : v;
	endfunction

	// expected entry point of one segment under the given edge tolerance
	function automatic entry_t predict_entry(input seg_t s, input logic [15:0] tol);
		longint lo[NAXIS], hi[NAXIS], org[NAXIS], dir[NAXIS], num[NAXIS], t[NAXIS];
		longint fc[NAXIS];
		longint unsigned n, d, q, prod, r;
		bit outside, neg;
		int p;
		entry_t e;
		e.hit = 1'b0;
		e.in_box = 1'b0;
		outside = 1'b0;
		for (int i = 0; i < NAXIS; i++) begin
			e.pt[i] = '0;
			lo[i] = s.bmin[i];
			hi[i] = s.bmax[i];
			org[i] = s.p0[i];
			dir[i] = longint'(s.p1[i]) - org[i];
			num[i] = 0;
			fc[i] = 0;
			t[i] = -(longint'(1) <<< TFRAC);
			if (org[i] > hi[i]) begin
				num[i] = hi[i] - org[i];
				fc[i] = hi[i];
				outside = 1'b1;
			end else if (org[i] < lo[i]) begin
				num[i] = lo[i] - org[i];
				fc[i] = lo[i];
				outside = 1'b1;
			end
			// distance rounded toward minus infinity
			if (num[i] != 0 && dir[i] != 0) begin
				n = absval(num[i]) << TFRAC;
				d = absval(dir[i]);
				q = n / d;
				neg = (num[i] < 0) != (dir[i] < 0);
				if (neg && (n % d) != 0)
					q++;
				t[i] = neg ? -longint'(q) : longint'(q);
			end
		end
		// start inside the box
		if (!outside) begin
			e.hit = 1'b1;
			e.in_box = 1'b1;
			for (int i = 0; i < NAXIS; i++)
				e.pt[i] = org[i][CW-1:0];
			return e;
		end
		// pick the plane, lower axis wins a tie
		p = 0;
		if (t[1] > t[p])
			p = 1;
		if (t[2] > t[p])
			p = 2;
		if (t[p] < 0)
			return e;
		if (absval(num[p]) > absval(dir[p]))
			return e;
		for (int i = 0; i < NAXIS; i++) begin
			if (i != p) begin
				prod = longint'(t[p]) * absval(dir[i]);
				r = prod >> TFRAC;
				if (dir[i] >= 0)
					fc[i] = org[i] + longint'(r);
				else
					fc[i] = org[i] - longint'(r) - ((prod[TFRAC-1:0] != 0) ? 1 : 0);
				if (fc[i] + longint'(tol) < lo[i] || fc[i] > hi[i] + longint'(tol))
					return e;
			end
		end
		e.hit = 1'b1;
		for (int i = 0; i < NAXIS; i++)
			e.pt[i] = fc[i][CW-1:0];
		return e;
	endfunction

	function automatic seg_t mk_seg(input longint a0, a1, a2, b0, b1, b2,
		input longint s0, s1, s2, e0, e1, e2);
		seg_t s;
		s.bmin = '{coord_t'(a0), coord_t'(a1), coord_t'(a2)};
		s.bmax = '{coord_t'(b0), coord_t'(b1), coord_t'(b2)};
		s.p0 = '{coord_t'(s0), coord_t'(s1), coord_t'(s2)};
		s.p1 = '{coord_t'(e0), coord_t'(e1), coord_t'(e2)};
		return s;
	endfunction

	function automatic entry_t mk_entry(input bit h, input bit ins, input longint x, y, z);
		entry_t e;
		e.hit = h;
		e.in_box = ins;
		e.pt = '{coord_t'(x), coord_t'(y), coord_t'(z)};
		return e;
	endfunction

	task automatic add_row(input seg_t s, input bit typed, input entry_t want);
		row_t r;
		r.s = s;
		r.typed = typed;
		r.want = want;
		dir_rows = {dir_rows, r};
	endtask

	// random segment, mostly aimed through a box so that hits are common
	function automatic seg_t rand_seg();
		seg_t s;
		int mode;
		longint c, h, tgt, off;
		mode = $urandom_range(0, 9);
		for (int i = 0; i < NAXIS; i++) begin
			if (mode < 2) begin
				s.bmin[i] = $urandom;
				s.bmax[i] = $urandom;
				s.p0[i] = $urandom;
				s.p1[i] = $urandom;
			end else begin
				c = longint'(int'($urandom)) >>> 3;
				h = $urandom_range(0, 1 << $urandom_range(0, 20));
				s.bmin[i] = coord_t'(c - h);
				s.bmax[i] = coord_t'(c + h);
				if (mode == 2 && $urandom_range(0, 3) == 0) begin
					s.bmin[i] = coord_t'(c + h);
					s.bmax[i] = coord_t'(c - h);
				end
				// target near a face on edge rows, anywhere in the box otherwise
				if (mode == 3)
					tgt = (($urandom_range(0, 1) != 0) ? c + h : c - h)
						+ $urandom_range(0, 6) - 3;
				else
					tgt = c - h + longint'($urandom_range(0, 2 * h));
				off = longint'($urandom_range(0, 1 << $urandom_range(0, 26)));
				if ($urandom_range(0, 1) != 0)
					off = -off;
				s.p0[i] = coord_t'(tgt + off);
				case ($urandom_range(0, 3))
					0: s.p1[i] = coord_t'(tgt);
					1: s.p1[i] = coord_t'(tgt - off);
					2: s.p1[i] = coord_t'(tgt + off / 2);
					default: s.p1[i] = coord_t'(tgt - off * 3);
				endcase
			end
		end
		return s;
	endfunction

	// send one item, expectation queued at acceptance
	task automatic send_seg(input seg_t s, input int gap);
		if (gap > 0) begin
			seg_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		seg_if.valid <= 1'b1;
		seg_if.box_min_x <= s.bmin[0];
		seg_if.box_min_y <= s.bmin[1];
		seg_if.box_min_z <= s.bmin[2];
		seg_if.box_max_x <= s.bmax[0];
		seg_if.box_max_y <= s.bmax[1];
		seg_if.box_max_z <= s.bmax[2];
		seg_if.seg_start_x <= s.p0[0];
		seg_if.seg_start_y <= s.p0[1];
		seg_if.seg_start_z <= s.p0[2];
		seg_if.seg_end_x <= s.p1[0];
		seg_if.seg_end_y <= s.p1[1];
		seg_if.seg_end_z <= s.p1[2];
		do @(posedge clk); while (!seg_if.ready);
		@(negedge clk);
	endtask

	// register write while the block is idle
	task automatic write_tol(input logic [15:0] v);
		seg_if.valid <= 1'b0;
		while (entry_q.size() != 0)
			@(negedge clk);
		repeat (LATENCY) @(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.data <= v;
		do @(posedge clk); while (!cfg_if.ready);
		tol_shadow = v;
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	// expectation bookkeeping on accepted input items
	always @(posedge clk) begin
		seg_t s;
		if (arst_n && seg_if.valid && seg_if.ready) begin
			s = mk_seg(seg_if.box_min_x, seg_if.box_min_y, seg_if.box_min_z,
				seg_if.box_max_x, seg_if.box_max_y, seg_if.box_max_z,
				seg_if.seg_start_x, seg_if.seg_start_y, seg_if.seg_start_z,
				seg_if.seg_end_x, seg_if.seg_end_y, seg_if.seg_end_z);
			if (dir_rows.size() != 0 && dir_rows[0].typed)
				entry_q = {entry_q, dir_rows[0].want};
			else
				entry_q = {entry_q, predict_entry(s, tol_shadow)};
			if (dir_rows.size() != 0)
				void'(dir_rows.pop_front());
		end
	end

	// result receiver with random stalls and one long hold
	initial begin
		int gap;
		bit quiet;
		entry_t e;
		res_if.ready = 1'b0;
		rx_count = 0;
		errors = 0;
		quiet = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (rx_count % 80 == 0)
				quiet = ($urandom_range(0, 2) == 0);
			gap = quiet ? 0 : $urandom_range(0, 13);
			if (rx_count == 500)
				gap = LONG_HOLD;
			if (gap > 0) begin
				res_if.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			res_if.ready <= 1'b1;
			do @(posedge clk); while (!res_if.valid);
			rx_count++;
			if (entry_q.size() == 0) begin
				$display("%0t: result with nothing expected: hit=%0b inside=%0b pt=%0d,%0d,%0d",
					$time, res_if.hit, res_if.starts_inside, res_if.hit_x, res_if.hit_y,
					res_if.hit_z);
				errors++;
			end else begin
				e = entry_q.pop_front();
				if (res_if.hit !== e.hit || res_if.starts_inside !== e.in_box ||
					res_if.hit_x !== e.pt[0] || res_if.hit_y !== e.pt[1] ||
					res_if.hit_z !== e.pt[2]) begin
					$display("%0t: mismatch expected hit=%0b inside=%0b pt=%0d,%0d,%0d actual hit=%0b inside=%0b pt=%0d,%0d,%0d",
						$time, e.hit, e.in_box, e.pt[0], e.pt[1], e.pt[2], res_if.hit,
						res_if.starts_inside, res_if.hit_x, res_if.hit_y, res_if.hit_z);
					errors++;
				end
			end
			@(negedge clk);
		end
	end

	// watchdog on cycles with no accepted item anywhere
	always @(posedge clk) begin
		if ((seg_if.valid && seg_if.ready) || (res_if.valid && res_if.ready) ||
			(cfg_if.valid && cfg_if.ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb_ray_box_intersect_top failed");
			$finish;
		end
	end

	// stimulus
	initial begin
		longint mx, mn;
		logic [15:0] tols[6];
		bit quiet;
		idle_cycles = 0;
		arst_n = 1'b0;
		tol_shadow = 16'd1;
		seg_if.valid = 1'b0;
		{seg_if.box_min_x, seg_if.box_min_y, seg_if.box_min_z} = '0;
		{seg_if.box_max_x, seg_if.box_max_y, seg_if.box_max_z} = '0;
		{seg_if.seg_start_x, seg_if.seg_start_y, seg_if.seg_start_z} = '0;
		{seg_if.seg_end_x, seg_if.seg_end_y, seg_if.seg_end_z} = '0;
		cfg_if.valid = 1'b0;
		cfg_if.data = '0;
		mx = 64'sd2147483647;
		mn = -64'sd2147483648;

		// directed rows: inside, extremes and the special cases
		add_row(mk_seg(0, 0, 0, 100, 100, 100, 50, 50, 50, 0, 0, 0), 1,
			mk_entry(1, 1, 50, 50, 50));
		add_row(mk_seg(0, 0, 0, 100, 100, 100, 100, 0, 100, 300, 300, 300), 1,
			mk_entry(1, 1, 100, 0, 100));
		add_row(mk_seg(mx, mx, mx, mx, mx, mx, mx, mx, mx, mn, mn, mn), 1,
			mk_entry(1, 1, mx, mx, mx));
		add_row(mk_seg(mn, mn, mn, mn, mn, mn, mn, mn, mn, mx, mx, mx), 1,
			mk_entry(1, 1, mn, mn, mn));
		add_row(mk_seg(mn, mn, mn, mx, mx, mx, mn, mx, mn, mx, mn, mx), 1,
			mk_entry(1, 1, mn, mx, mn));
		add_row(mk_seg(0, 0, 0, 10, 10, 10, -10, 5, 5, 20, 5, 5), 1,
			mk_entry(1, 0, 0, 5, 5));
		add_row(mk_seg(0, 0, 0, 10, 10, 10, -10, 5, 5, -20, 5, 5), 1,
			mk_entry(0, 0, 0, 0, 0));
		add_row(mk_seg(0, 0, 0, 10, 10, 10, -10, 5, 5, -5, 5, 5), 1,
			mk_entry(0, 0, 0, 0, 0));
		add_row(mk_seg(0, 0, 0, 10, 10, 10, -10, 5, 5, -10, 5, 5), 1,
			mk_entry(0, 0, 0, 0, 0));
		add_row(mk_seg(0, 0, 0, 10, 10, 10, -10, 5, 5, 0, 5, 5), 0, mk_entry(0, 0, 0, 0, 0));
		add_row(mk_seg(0, 0, 0, 10, 10, 10, 20, 5, 5, -20, 5, 5), 0, mk_entry(0, 0, 0, 0, 0));
		add_row(mk_seg(0, 0, 0, 10, 10, 10, 5, -30, 5, 3, 30, 8), 0, mk_entry(0, 0, 0, 0, 0));
		add_row(mk_seg(0, 0, 0, 10, 10, 10, 5, 4, 40, 6, 9, -40), 0, mk_entry(0, 0, 0, 0, 0));
		add_row(mk_seg(0, 0, 0, 10, 10, 10, -10, -10, 5, 10, 10, 5), 0,
			mk_entry(0, 0, 0, 0, 0));
		add_row(mk_seg(10, 0, 0, 0, 10, 10, 5, 5, 5, 20, 5, 5), 0, mk_entry(0, 0, 0, 0, 0));
		add_row(mk_seg(10, 0, 0, 0, 10, 10, -5, 5, 5, 20, 7, 3), 0, mk_entry(0, 0, 0, 0, 0));
		add_row(mk_seg(0, 0, 0, 1000, 1000, 1000, -1000, 1001, 500, 1000, 1001, 500), 0,
			mk_entry(0, 0, 0, 0, 0));
		add_row(mk_seg(0, 0, 0, 1000, 1000, 1000, -1000, 1002, 500, 1000, 1002, 500), 0,
			mk_entry(0, 0, 0, 0, 0));
		add_row(mk_seg(0, 0, 0, 1000, 1000, 1000, -1000, -1, -2, 1000, -1, -2), 0,
			mk_entry(0, 0, 0, 0, 0));
		add_row(mk_seg(0, 0, 0, 1000, 1000, 1000, -7, 999, 3, 994, -3, 1001), 0,
			mk_entry(0, 0, 0, 0, 0));
		add_row(mk_seg(mx - 5, mx - 5, mx - 5, mx, mx, mx, mn, mn, mn, mx, mx, mx), 0,
			mk_entry(0, 0, 0, 0, 0));
		add_row(mk_seg(mn, mn, mn, mn + 3, mn + 3, mn + 3, mx, mx, mx, mn, mn, mn), 0,
			mk_entry(0, 0, 0, 0, 0));
		add_row(mk_seg(0, 0, 0, 1, 1, 1, mx, 0, 0, mn, 1, 1), 0, mk_entry(0, 0, 0, 0, 0));

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part under the reset tolerance
		while (dir_rows.size() != 0)
			send_seg(dir_rows[0].s, $urandom_range(0, 3));
		seg_if.valid <= 1'b0;
		while (dir_rows.size() != 0 || entry_q.size() != 0)
			@(negedge clk);

		// random phases across tolerance settings
		tols = '{16'd0, 16'd65535, 16'($urandom), 16'd3, 16'd200, 16'd1};
		quiet = 1'b0;
		for (int ph = 0; ph < 6; ph++) begin
			write_tol(tols[ph]);
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				if (k % 60 == 0)
					quiet = ($urandom_range(0, 2) == 0);
				// drain everything once mid-run
				if (ph == 2 && k == 100) begin
					seg_if.valid <= 1'b0;
					while (entry_q.size() != 0)
						@(negedge clk);
				end
				send_seg(rand_seg(), quiet ? 0 : $urandom_range(0, 13));
			end
		end
		seg_if.valid <= 1'b0;

		// drain and settle
		while (entry_q.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0)
			$display("tb_ray_box_intersect_top passed");
		else
			$display("tb_ray_box_intersect_top failed");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/rbi_pkg.sv
rtl/rbi_if.sv
rtl/rbi_div.sv
rtl/ray_box_intersect_top.sv
tb/tb_ray_box_intersect_top.sv
